FILE: src/fds_pkg.sv
// Package for the fall detection state machine: phase and verdict codes,
// register indexes, reset values and the sample and result transaction types.
// Depends on nothing; fall_detect_state_machine imports it.
package fds_pkg;

	// Widths of the configuration port.
	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W  = 32;

	// Extra time beyond the free-fall duration before free fall times out.
	localparam logic [31:0] FF_TIMEOUT_EXTRA_MS = 32'd2000;

	// Register reset values.
	localparam logic [11:0] RST_FREEFALL_LEVEL   = 12'd90;
	localparam logic [11:0] RST_IMPACT_LEVEL     = 12'd640;
	localparam logic [10:0] RST_TILT_ALARM_ANGLE = 11'd600;
	localparam logic [10:0] RST_POSTURE_ANGLE    = 11'd600;
	localparam logic [15:0] RST_FREEFALL_TIME    = 16'd100;
	localparam logic [31:0] RST_TILT_ALARM_TIME  = 32'd10000;
	localparam logic [31:0] RST_POSTURE_WINDOW   = 32'd2000;
	localparam logic [7:0]  RST_VOTE_FRAMES      = 8'd3;

	// Detector phases.
	typedef enum logic [2:0] {
		PH_NORMAL    = 3'd0,
		PH_FREEFALL  = 3'd1,
		PH_IMPACT    = 3'd2,
		PH_POST      = 3'd3,
		PH_CONFIRMED = 3'd4
	} phase_t;

	// Verdict codes.
	typedef enum logic [1:0] {
		VERDICT_NORMAL = 2'd0,
		VERDICT_TILT   = 2'd1,
		VERDICT_FALL   = 2'd2
	} verdict_t;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FREEFALL_LEVEL   = 8'd0,
		REG_IMPACT_LEVEL     = 8'd1,
		REG_TILT_ALARM_ANGLE = 8'd2,
		REG_POSTURE_ANGLE    = 8'd3,
		REG_FREEFALL_TIME    = 8'd4,
		REG_TILT_ALARM_TIME  = 8'd5,
		REG_POSTURE_WINDOW   = 8'd6,
		REG_VOTE_FRAMES      = 8'd7
	} cfg_reg_t;

	// One input sample.
	typedef struct packed {
		logic [31:0] time_ms;
		logic [11:0] accel_level;
		logic [10:0] trunk_angle;
	} sample_t;

	// One result.
	typedef struct packed {
		logic [1:0] verdict;
		logic [2:0] phase;
	} result_t;

	// Outcome of one debounce vote.
	typedef struct packed {
		phase_t     cand;
		logic [7:0] cnt;
		logic       pass;
	} vote_t;

endpackage

FILE: src/fall_detect_state_machine.sv
// Top level of the fall detection state machine: input register, phase logic,
// tilt alarm, configuration registers and result register.
// Depends on fds_pkg.

// One sample is taken every clock cycle unless the input stalls; each sample gives
// exactly one result, held first in the input register and then in the
// result register. The phase and timer update is a few 32-bit subtractions
// and compares between those two registers. The result register lets a new
// sample enter while an earlier result waits; the input stalls only when a
// sample is waiting and the result register is full and stalled. Fall
// confirmed holds until reset. Configuration writes are always ready and
// take effect on samples that reach the phase logic afterwards.
module fall_detect_state_machine
	import fds_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  sample_t                sample,
	output logic                   result_valid,
	input  logic                   result_stall,
	output result_t                result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_value
);

	// Configuration registers.
	logic [11:0] freefall_level_q;
	logic [11:0] impact_level_q;
	logic [10:0] tilt_alarm_angle_q;
	logic [10:0] posture_angle_q;
	logic [15:0] freefall_time_q;
	logic [31:0] tilt_alarm_time_q;
	logic [31:0] posture_window_q;
	logic [7:0]  vote_frames_q;

	// Detector state.
	phase_t      phase_q;
	phase_t      cand_q;
	logic [7:0]  vote_q;
	logic [31:0] fall_start_q;
	logic [31:0] impact_time_q;
	logic [31:0] tilt_start_q;

	// Input stage and result register.
	logic        valid_s1;
	sample_t     sample_s1;
	logic        result_valid_q;
	result_t     result_q;

	// Next-state values.
	phase_t      phase_d;
	phase_t      cand_d;
	logic [7:0]  vote_d;
	logic [31:0] fall_start_d;
	logic [31:0] impact_time_d;
	logic [31:0] tilt_start_d;
	verdict_t    verdict_d;

	logic        advance;
	logic        take_sample;

	// Cast one debounce vote for phase p.
	function automatic vote_t cast_vote(phase_t p, phase_t cand, logic [7:0] cnt,
		logic [7:0] need);
		vote_t v;
		v.cand = p;
		if (cand == p) begin
			v.cnt = cnt + 8'd1;
		end else begin
			v.cnt = 8'd1;
		end
		v.pass = (v.cnt >= need);
		return v;
	endfunction

	// Handshake: the sample in the input stage moves on when the result
	// register is empty or its transaction completes in this cycle.
	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && result_valid_q && result_stall;
	assign take_sample  = sample_valid && !sample_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

	// Configuration writes; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freefall_level_q   <= RST_FREEFALL_LEVEL;
			impact_level_q     <= RST_IMPACT_LEVEL;
			tilt_alarm_angle_q <= RST_TILT_ALARM_ANGLE;
			posture_angle_q    <= RST_POSTURE_ANGLE;
			freefall_time_q    <= RST_FREEFALL_TIME;
			tilt_alarm_time_q  <= RST_TILT_ALARM_TIME;
			posture_window_q   <= RST_POSTURE_WINDOW;
			vote_frames_q      <= RST_VOTE_FRAMES;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FREEFALL_LEVEL:   freefall_level_q   <= cfg_value[11:0];
				REG_IMPACT_LEVEL:     impact_level_q     <= cfg_value[11:0];
				REG_TILT_ALARM_ANGLE: tilt_alarm_angle_q <= cfg_value[10:0];
				REG_POSTURE_ANGLE:    posture_angle_q    <= cfg_value[10:0];
				REG_FREEFALL_TIME:    freefall_time_q    <= cfg_value[15:0];
				REG_TILT_ALARM_TIME:  tilt_alarm_time_q  <= cfg_value[31:0];
				REG_POSTURE_WINDOW:   posture_window_q   <= cfg_value[31:0];
				REG_VOTE_FRAMES:      vote_frames_q      <= cfg_value[7:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_sample) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (take_sample) begin
			sample_s1 <= sample;
		end
	end

	// Next phase, debounce votes and phase timers.
	always_comb begin
		vote_t       v;
		logic [31:0] now;
		logic [31:0] ff_timeout;
		now           = sample_s1.time_ms;
		ff_timeout    = 32'(freefall_time_q) + FF_TIMEOUT_EXTRA_MS;
		v             = '0;
		phase_d       = phase_q;
		cand_d        = cand_q;
		vote_d        = vote_q;
		fall_start_d  = fall_start_q;
		impact_time_d = impact_time_q;
		unique case (phase_q)
			PH_NORMAL: begin
				// Low magnitude starts the free-fall timer and votes once
				// it has run long enough; otherwise everything clears.
				if (sample_s1.accel_level < freefall_level_q) begin
					if (fall_start_q == 32'd0) begin
						fall_start_d = now;
					end
					if ((now - fall_start_d) >= 32'(freefall_time_q)) begin
						v      = cast_vote(PH_FREEFALL, cand_d, vote_d, vote_frames_q);
						cand_d = v.cand;
						vote_d = v.cnt;
						if (v.pass) begin
							phase_d = PH_FREEFALL;
						end
					end
				end else begin
					fall_start_d = 32'd0;
					cand_d       = PH_NORMAL;
					vote_d       = 8'd0;
				end
				// The impact vote comes second and wins if it passes.
				if (sample_s1.accel_level > impact_level_q) begin
					v      = cast_vote(PH_IMPACT, cand_d, vote_d, vote_frames_q);
					cand_d = v.cand;
					vote_d = v.cnt;
					if (v.pass) begin
						phase_d = PH_IMPACT;
					end
				end
			end
			PH_FREEFALL: begin
				if (sample_s1.accel_level > impact_level_q) begin
					v      = cast_vote(PH_IMPACT, cand_d, vote_d, vote_frames_q);
					cand_d = v.cand;
					vote_d = v.cnt;
					if (v.pass) begin
						phase_d = PH_IMPACT;
					end
				end
				// A free fall that lasts too long votes back to normal.
				if ((now - fall_start_q) > ff_timeout) begin
					v      = cast_vote(PH_NORMAL, cand_d, vote_d, vote_frames_q);
					cand_d = v.cand;
					vote_d = v.cnt;
					if (v.pass) begin
						phase_d = PH_NORMAL;
					end
				end
			end
			PH_IMPACT: begin
				impact_time_d = now;
				phase_d       = PH_POST;
			end
			PH_POST: begin
				// Lying posture inside the window votes for a confirmed fall.
				if ((now - impact_time_q) <= posture_window_q) begin
					if (sample_s1.trunk_angle > posture_angle_q) begin
						v      = cast_vote(PH_CONFIRMED, cand_d, vote_d, vote_frames_q);
						cand_d = v.cand;
						vote_d = v.cnt;
						if (v.pass) begin
							phase_d = PH_CONFIRMED;
						end
					end
				end else begin
					phase_d = PH_NORMAL;
				end
			end
			default: begin
				phase_d = PH_CONFIRMED;
			end
		endcase
		// Entering a phase restarts the debounce.
		if (phase_d != phase_q || phase_d == PH_CONFIRMED) begin
			cand_d = phase_d;
			vote_d = 8'd0;
		end
	end

	// Verdict and tilt alarm timer, from the phase after this sample.
	always_comb begin
		logic [31:0] now;
		now          = sample_s1.time_ms;
		tilt_start_d = tilt_start_q;
		verdict_d    = (phase_d == PH_CONFIRMED) ? VERDICT_FALL : VERDICT_NORMAL;
		if (phase_d == PH_NORMAL && sample_s1.trunk_angle > tilt_alarm_angle_q) begin
			if (tilt_start_q == 32'd0) begin
				tilt_start_d = now;
			end
			if ((now - tilt_start_d) >= tilt_alarm_time_q) begin
				verdict_d = VERDICT_TILT;
			end
		end else if (sample_s1.trunk_angle <= tilt_alarm_angle_q) begin
			tilt_start_d = 32'd0;
		end
	end

	// Detector state and result valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_NORMAL;
			cand_q         <= PH_NORMAL;
			vote_q         <= 8'd0;
			fall_start_q   <= 32'd0;
			impact_time_q  <= 32'd0;
			tilt_start_q   <= 32'd0;
			result_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q        <= phase_d;
				cand_q         <= cand_d;
				vote_q         <= vote_d;
				fall_start_q   <= fall_start_d;
				impact_time_q  <= impact_time_d;
				tilt_start_q   <= tilt_start_d;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.verdict <= verdict_d;
			result_q.phase   <= phase_d;
		end
	end

`ifndef SYNTHESIS
	// A confirmed fall is never left.
	a_confirmed_holds: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CONFIRMED |=> phase_q == PH_CONFIRMED)
		else $error("confirmed phase was left");

	// A phase change always restarts the debounce count.
	a_vote_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_d != phase_q) |=> vote_q == 8'd0)
		else $error("vote count not cleared on phase change");

	// A waiting result always reports the current phase.
	a_result_phase: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.phase == phase_q)
		else $error("result phase differs from detector phase");

	// Every sample that leaves the input stage produces a result.
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("sample processed without a result");
`endif

endmodule
